FILE: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants and types of the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NumPages = 1024;
  localparam int MaxOrder = 10;
  localparam int PW = $clog2(NumPages);
  localparam int NumLists = MaxOrder + 1;
  localparam int LW = $clog2(NumLists);
  localparam int CW = PW + 1;

  typedef logic [PW-1:0] page_t;
  typedef logic [3:0]    ord_t;
  typedef logic [LW-1:0] lidx_t;
  typedef logic [CW-1:0] cnt_t;

  localparam logic [1:0] ActAlloc = 2'd0;
  localparam logic [1:0] ActFree  = 2'd1;
  localparam logic [1:0] ActAdd   = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoFree = 2'd1;
  localparam logic [1:0] StTooBig = 2'd2;

  // page record: free mark, order and list links
  typedef struct packed {
    logic  free;
    ord_t  order;
    page_t nxt;
    page_t prv;
  } prec_t;

endpackage

FILE: rtl/core/buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// buddy allocator with fifo free lists per order over a page record memory
// ----------------------------------------------------------------------------
//  channel  | signals                                              | dir
//  request  | valid, stall, action, page_number, block_order,      | in
//           | block_count                                          |
//  response | out_valid, out_stall, status, result_page,           | out
//           | result_order                                         |
// one request at a time; a record read goes through the registered read port to its data
// alloc: scan the orders upward, unlink the head, split one order per level, end
// free: read the page, merge step by step with free buddies, append, end
// add: S_NEXTB then the free sequence per block; the response goes through res_pend
// after reset a pass clears every record, stall stays high meanwhile
// the response register holds while stalled; no request is taken while res_pend waits
module buddy_page_allocator_top
  import bpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       stall,
  input  logic [1:0] action,
  input  page_t      page_number,
  input  ord_t       block_order,
  input  cnt_t       block_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output page_t      result_page,
  output ord_t       result_order
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SCAN   = 14'b00000000000010,
    S_RDHEAD = 14'b00000000000100,
    S_SPLIT  = 14'b00000000001000,
    S_RDTAIL = 14'b00000000010000,
    S_WRTAIL = 14'b00000000100000,
    S_FINA   = 14'b00000001000000,
    S_RDP    = 14'b00000010000000,
    S_RDB    = 14'b00000100000000,
    S_RMA    = 14'b00001000000000,
    S_RMB    = 14'b00010000000000,
    S_INS    = 14'b00100000000000,
    S_NEXTB  = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } st_t;

  st_t st;
  logic [1:0] act;
  ord_t req_ord, cur_ord;
  page_t cur_p, res_page, blk;
  cnt_t cnt;
  logic [PW:0] add_p;
  logic [1:0] sub;

  // list heads, tails and lengths as small register files
  page_t first [NumLists];
  page_t last  [NumLists];
  cnt_t  len   [NumLists];

  logic  we;
  page_t waddr, raddr;
  prec_t wdata, rdata;
  prec_t rec;
  logic  clearing;

  bpa_mem u_mem (
    .clk(clk), .rst(rst), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata), .clearing(clearing)
  );

  logic res_pend;
  logic [1:0] res_st;
  ord_t res_ord;

  assign stall = (st != S_IDLE) || res_pend || clearing;

  logic [PW:0] half_w, buddy_w;
  assign half_w  = {1'b0, cur_p} + ({{PW{1'b0}}, 1'b1} << (cur_ord - 4'd1));
  assign buddy_w = {1'b0, cur_p} ^ ({{PW{1'b0}}, 1'b1} << cur_ord);

  lidx_t ci;
  assign ci = cur_ord[LW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
      res_pend <= 1'b0;
      we <= 1'b0;
      for (int i = 0; i < NumLists; i++) begin
        len[i] <= '0;
      end
    end else begin
      we <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (res_pend && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        status <= res_st;
        result_page <= res_page;
        result_order <= res_ord;
        res_pend <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (valid && !stall) begin
            act <= action;
            req_ord <= block_order;
            cur_ord <= block_order;
            cnt <= block_count;
            add_p <= {1'b0, page_number};
            cur_p <= page_number;
            res_st <= StOk;
            res_page <= '0;
            res_ord <= '0;
            sub <= 2'd0;
            if ((action == ActAlloc || action == ActAdd) &&
                block_order > ord_t'(MaxOrder)) begin
              res_st <= StTooBig;
              st <= S_DONE;
            end else if (action == ActAlloc) begin
              res_st <= StNoFree;
              st <= S_SCAN;
            end else if (action == ActFree) begin
              st <= S_RDP;
            end else if (action == ActAdd) begin
              st <= S_NEXTB;
            end else begin
              st <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (len[ci] != '0) begin
            cur_p <= first[ci];
            raddr <= first[ci];
            sub <= 2'd0;
            st <= S_RDHEAD;
          end else if (cur_ord == ord_t'(MaxOrder)) begin
            st <= S_DONE;
          end else begin
            cur_ord <= cur_ord + 4'd1;
          end
        end
        S_RDHEAD: begin
          // remove the head: its next becomes the list head
          sub <= sub + 2'd1;
          if (sub == 2'd1) begin
            first[ci] <= rdata.nxt;
            if (len[ci] == cnt_t'(1)) begin
              last[ci] <= rdata.prv;
            end
            len[ci] <= len[ci] - cnt_t'(1);
            st <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (cur_ord == req_ord) begin
            we <= 1'b1;
            waddr <= cur_p;
            wdata <= '{free: 1'b0, order: req_ord, nxt: '0, prv: '0};
            res_st <= StOk;
            res_page <= cur_p;
            res_ord <= req_ord;
            st <= S_FINA;
          end else begin
            cur_ord <= cur_ord - 4'd1;
            if (half_w < (PW+1)'(NumPages)) begin
              blk <= half_w[PW-1:0];
              raddr <= last[lidx_t'(cur_ord - 4'd1)];
              sub <= 2'd0;
              st <= S_RDTAIL;
            end
          end
        end
        S_RDTAIL: begin
          // read tail record to link the new entry behind it
          sub <= sub + 2'd1;
          if (sub == 2'd1) begin
            rec <= rdata;
            sub <= 2'd0;
            st <= S_WRTAIL;
          end
        end
        S_WRTAIL: begin
          sub <= sub + 2'd1;
          if (sub == 2'd0) begin
            we <= 1'b1;
            waddr <= blk;
            wdata <= '{free: 1'b1, order: cur_ord, nxt: '0, prv: last[ci]};
          end else if (sub == 2'd1) begin
            if (len[ci] != '0) begin
              we <= 1'b1;
              waddr <= last[ci];
              wdata <= '{free: rec.free, order: rec.order, nxt: blk, prv: rec.prv};
            end else begin
              first[ci] <= blk;
            end
            last[ci] <= blk;
            len[ci] <= len[ci] + cnt_t'(1);
            st <= (act == ActAlloc) ? S_SPLIT : S_DONE;
            if (act != ActAlloc) begin
              res_ord <= cur_ord;
              st <= (act == ActAdd) ? S_NEXTB : S_DONE;
            end
          end
        end
        S_FINA: begin
          st <= S_DONE;
        end
        S_NEXTB: begin
          if (cnt == '0 || add_p[PW]) begin
            st <= S_DONE;
          end else begin
            cnt <= cnt - cnt_t'(1);
            cur_p <= add_p[PW-1:0];
            cur_ord <= req_ord;
            add_p <= add_p + ((PW+1)'(1) << req_ord);
            st <= S_RDP;
          end
          sub <= 2'd0;
        end
        S_RDP: begin
          // read the page being freed
          raddr <= cur_p;
          sub <= sub + 2'd1;
          if (sub == 2'd2) begin
            sub <= 2'd0;
            if (rdata.free) begin
              res_ord <= rdata.order;
              st <= (act == ActAdd) ? S_NEXTB : S_DONE;
            end else begin
              if (act == ActFree) begin
                cur_ord <= rdata.order;
              end
              st <= S_RDB;
            end
          end
        end
        S_RDB: begin
          // check the buddy; merge while free and same order
          sub <= sub + 2'd1;
          if (sub == 2'd0) begin
            if (cur_ord >= ord_t'(MaxOrder) || buddy_w >= (PW+1)'(NumPages)) begin
              blk <= cur_p;
              raddr <= last[ci];
              sub <= 2'd0;
              st <= S_RDTAIL;
            end else begin
              raddr <= buddy_w[PW-1:0];
            end
          end else if (sub == 2'd2) begin
            sub <= 2'd0;
            if (rdata.free && rdata.order == cur_ord) begin
              rec <= rdata;
              blk <= raddr;
              st <= S_RMA;
            end else begin
              blk <= cur_p;
              raddr <= last[ci];
              st <= S_RDTAIL;
            end
          end
        end
        S_RMA: begin
          // unlink buddy: fix predecessor's next or the head
          sub <= sub + 2'd1;
          if (sub == 2'd0) begin
            if (blk != first[ci]) begin
              raddr <= rec.prv;
            end
          end else if (sub == 2'd2) begin
            sub <= 2'd0;
            if (blk == first[ci]) begin
              first[ci] <= rec.nxt;
            end else begin
              we <= 1'b1;
              waddr <= rec.prv;
              wdata <= '{free: rdata.free, order: rdata.order, nxt: rec.nxt,
                         prv: rdata.prv};
            end
            if (blk != last[ci]) begin
              raddr <= rec.nxt;
            end
            st <= S_RMB;
          end
        end
        S_RMB: begin
          sub <= sub + 2'd1;
          if (sub == 2'd1) begin
            sub <= 2'd0;
            if (blk == last[ci]) begin
              last[ci] <= rec.prv;
            end else begin
              we <= 1'b1;
              waddr <= rec.nxt;
              wdata <= '{free: rdata.free, order: rdata.order, nxt: rdata.nxt,
                         prv: rec.prv};
            end
            len[ci] <= len[ci] - cnt_t'(1);
            st <= S_INS;
          end
        end
        S_INS: begin
          // clear buddy mark, grow block
          sub <= sub + 2'd1;
          if (sub == 2'd0) begin
            we <= 1'b1;
            waddr <= blk;
            wdata <= '{free: 1'b0, order: rec.order, nxt: rec.nxt, prv: rec.prv};
          end else begin
            sub <= 2'd0;
            cur_p <= cur_p & blk;
            cur_ord <= cur_ord + 4'd1;
            st <= S_RDB;
          end
        end
        S_DONE: begin
          if (!res_pend) begin
            res_pend <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bpa_mem.sv
// ----------------------------------------------------------------------------
// bpa_mem
// page record memory, one write and one registered read port, with a
// clearing pass over every record after reset
// ----------------------------------------------------------------------------
module bpa_mem
  import bpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  we,
  input  page_t waddr,
  input  prec_t wdata,
  input  page_t raddr,
  output prec_t rdata,
  output logic  clearing
);

  prec_t mem [NumPages];
  page_t clr_addr;

  // walk every record once after reset so that no page reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + page_t'(1);
      if (clr_addr == page_t'(NumPages - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed requests against buddy_page_allocator_top; a shadow
// allocator predicts every response, the monitor compares them in order
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;

  localparam logic [1:0] ActNone = 2'd3;
  localparam int NumRandom = 925;
  localparam int QuietTail = 100;
  localparam int WatchLimit = 200000;
  localparam int DrainCycles = 300;

  typedef struct packed {
    logic [1:0] act;
    page_t      pg;
    ord_t       ord;
    cnt_t       cnt;
  } request_t;

  typedef struct packed {
    logic [1:0] st;
    page_t      pg;
    ord_t       ord;
  } response_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       valid = 1'b0;
  logic       stall;
  logic [1:0] action = ActAlloc;
  page_t      page_number = '0;
  ord_t       block_order = '0;
  cnt_t       block_count = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  page_t      result_page;
  ord_t       result_order;

  buddy_page_allocator_top DUT (
    .clk(clk), .rst(rst),
    .valid(valid), .stall(stall), .action(action), .page_number(page_number),
    .block_order(block_order), .block_count(block_count),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .result_page(result_page), .result_order(result_order)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow allocator state
  bit free_mark [NumPages];
  int blk_ord   [NumPages];
  int lnk_next  [NumPages];
  int lnk_prev  [NumPages];
  int fl_head   [NumLists];
  int fl_tail   [NumLists];
  int fl_len    [NumLists];

  // stimulus bookkeeping: pages owned by some block, heads handed out
  bit covered [NumPages];
  int owned_heads [$];

  request_t  pending_q [$];
  response_t expected_q [$];
  int total_items;
  int sent = 0;
  int received = 0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic void fl_append(int o, int p);
    if (fl_len[o] == 0) begin
      fl_head[o] = p;
    end else begin
      lnk_next[fl_tail[o]] = p;
      lnk_prev[p] = fl_tail[o];
    end
    fl_tail[o] = p;
    fl_len[o]++;
  endfunction

  function automatic void fl_remove(int o, int p);
    if (fl_len[o] == 0) return;
    if (p == fl_head[o]) fl_head[o] = lnk_next[p];
    else lnk_next[lnk_prev[p]] = lnk_next[p];
    if (p == fl_tail[o]) fl_tail[o] = lnk_prev[p];
    else lnk_prev[lnk_next[p]] = lnk_prev[p];
    fl_len[o]--;
  endfunction

  function automatic int coalesce(int p, int o);
    int b;
    while (o < MaxOrder) begin
      b = p ^ (1 << o);
      if (b >= NumPages || !free_mark[b] || blk_ord[b] != o) break;
      fl_remove(o, b);
      free_mark[b] = 1'b0;
      p = p & b;
      o++;
    end
    free_mark[p] = 1'b1;
    blk_ord[p] = o;
    fl_append(o, p);
    return o;
  endfunction

  function automatic response_t allocator_response(request_t r);
    response_t rsp;
    int p;
    int h;
    rsp = '{st: StOk, pg: '0, ord: '0};
    if (r.act == ActAlloc) begin
      if (int'(r.ord) > MaxOrder) begin
        rsp.st = StTooBig;
      end else begin
        rsp.st = StNoFree;
        for (int nd = int'(r.ord); nd <= MaxOrder; nd++) begin
          if (fl_len[nd] != 0) begin
            p = fl_head[nd];
            fl_remove(nd, p);
            for (int o = nd; o > int'(r.ord); o--) begin
              h = p + (1 << (o - 1));
              // upper half beyond the region end is dropped
              if (h < NumPages) begin
                free_mark[h] = 1'b1;
                blk_ord[h] = o - 1;
                fl_append(o - 1, h);
              end
            end
            free_mark[p] = 1'b0;
            blk_ord[p] = int'(r.ord);
            rsp = '{st: StOk, pg: page_t'(p), ord: r.ord};
            break;
          end
        end
      end
    end else if (r.act == ActFree) begin
      if (free_mark[r.pg]) rsp.ord = ord_t'(blk_ord[r.pg]);
      else rsp.ord = ord_t'(coalesce(int'(r.pg), blk_ord[r.pg]));
    end else if (r.act == ActAdd) begin
      if (int'(r.ord) > MaxOrder) begin
        rsp.st = StTooBig;
      end else begin
        p = int'(r.pg);
        for (int i = 0; i < int'(r.cnt); i++) begin
          if (p >= NumPages) break;
          if (free_mark[p]) rsp.ord = ord_t'(blk_ord[p]);
          else rsp.ord = ord_t'(coalesce(p, int'(r.ord)));
          p += 1 << r.ord;
        end
      end
    end
    return rsp;
  endfunction

  // an add may only touch free heads or pages no block owns yet
  function automatic bit claim_pages(request_t r, bit commit);
    int p;
    int lim;
    p = int'(r.pg);
    for (int i = 0; i < int'(r.cnt); i++) begin
      if (p >= NumPages) break;
      if (!free_mark[p]) begin
        lim = p + (1 << r.ord);
        if (lim > NumPages) lim = NumPages;
        for (int q = p; q < lim; q++) begin
          if (commit) covered[q] = 1'b1;
          else if (covered[q]) return 1'b0;
        end
      end
      p += 1 << r.ord;
    end
    return 1'b1;
  endfunction

  task automatic queue_request(logic [1:0] act, int pg, int ord, int cnt);
    request_t  r;
    response_t rsp;
    r = '{act: act, pg: page_t'(pg), ord: ord_t'(ord), cnt: cnt_t'(cnt)};
    if (act == ActAdd && ord <= MaxOrder) void'(claim_pages(r, 1'b1));
    rsp = allocator_response(r);
    if (act == ActAlloc && rsp.st == StOk) owned_heads.push_back(int'(rsp.pg));
    pending_q.push_back(r);
    expected_q.push_back(rsp);
  endtask

  task automatic queue_noise();
    case ($urandom_range(0, 3))
      0: queue_request(ActAlloc, $urandom_range(0, 1023), $urandom_range(11, 15),
                       $urandom_range(0, 2047));
      1: queue_request(ActAdd, $urandom_range(0, 1023), $urandom_range(11, 15),
                       $urandom_range(0, 2047));
      2: queue_request(ActAdd, $urandom_range(0, 1023), $urandom_range(0, 10), 0);
      default: queue_request(ActNone, $urandom_range(0, 1023), $urandom_range(0, 15),
                             $urandom_range(0, 2047));
    endcase
  endtask

  task automatic queue_random_item();
    request_t r;
    int k;
    int pick;
    bit done;
    k = $urandom_range(0, 99);
    done = 1'b0;
    if (k < 35) begin
      queue_request(ActAlloc, $urandom_range(0, 1023),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10)
                                                : $urandom_range(0, 3), 0);
      done = 1'b1;
    end else if (k < 58) begin
      if (owned_heads.size() > 0) begin
        pick = $urandom_range(0, owned_heads.size() - 1);
        queue_request(ActFree, owned_heads[pick], $urandom_range(0, 15),
                      $urandom_range(0, 2047));
        owned_heads.delete(pick);
        done = 1'b1;
      end
    end else if (k < 65) begin
      // double free of a page already marked free
      for (int t = 0; t < 24 && !done; t++) begin
        pick = $urandom_range(0, NumPages - 1);
        if (free_mark[pick]) begin
          queue_request(ActFree, pick, $urandom_range(0, 15), $urandom_range(0, 2047));
          done = 1'b1;
        end
      end
    end else if (k < 92) begin
      for (int t = 0; t < 8 && !done; t++) begin
        r.act = ActAdd;
        r.ord = ($urandom_range(0, 3) == 0) ? ord_t'($urandom_range(0, 10))
                                            : ord_t'($urandom_range(0, 4));
        r.pg = page_t'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) < 7) r.pg = (r.pg >> r.ord) << r.ord;
        r.cnt = ($urandom_range(0, 9) == 0) ? cnt_t'($urandom_range(0, 1024))
                                            : cnt_t'($urandom_range(1, 4));
        if (claim_pages(r, 1'b0)) begin
          queue_request(ActAdd, int'(r.pg), int'(r.ord), int'(r.cnt));
          done = 1'b1;
        end
      end
    end
    if (!done) queue_noise();
  endtask

  // request driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (valid && !stall) begin
        void'(pending_q.pop_front());
        sent++;
      end
      if (!(valid && stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          valid <= 1'b0;
        end else if (sent < total_items - QuietTail && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 16);
          valid <= 1'b0;
        end else begin
          valid <= 1'b1;
          action <= pending_q[0].act;
          page_number <= pending_q[0].pg;
          block_order <= pending_q[0].ord;
          block_count <= pending_q[0].cnt;
        end
      end
    end
  end

  // response monitor and receiver stalls
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        received++;
        if (expected_q.size() == 0) begin
          $error("unexpected transfer: status %0d page %0d order %0d",
                 status, result_page, result_order);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors++;
          end
          if (result_page !== want.pg) begin
            $error("result_page: expected %0d, got %0d", want.pg, result_page);
            errors++;
          end
          if (result_order !== want.ord) begin
            $error("result_order: expected %0d, got %0d", want.ord, result_order);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && received >= 200) begin
        // long hold so the block backs up into the request side
        long_hold_done = 1'b1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else if (sent < total_items - QuietTail && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (valid && !stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    // directed: empty allocator, oversize orders, count zero, unknown action
    queue_request(ActAlloc, 0, 0, 0);
    queue_request(ActAlloc, 1023, 11, 0);
    queue_request(ActAlloc, 0, 15, 2047);
    queue_request(ActAdd, 1023, 15, 1024);
    queue_request(ActAdd, 1023, 10, 0);
    queue_request(ActNone, 1023, 15, 2047);
    // block reaching past the region end, split with its top half dropped
    queue_request(ActAdd, 1020, 3, 1);
    queue_request(ActAlloc, 0, 0, 0);
    queue_request(ActFree, 1020, 0, 0);
    queue_request(ActFree, 1020, 0, 0);
    // add walking into the end of the region over a free head
    queue_request(ActAdd, 1012, 3, 1024);
    queue_request(ActAdd, 0, 0, 4);
    queue_request(ActAdd, 4, 2, 2);
    queue_request(ActAdd, 0, 2, 1);
    queue_request(ActAdd, 512, 9, 1);
    queue_request(ActAdd, 256, 8, 1);
    queue_request(ActAlloc, 0, 10, 0);
    queue_request(ActAlloc, 0, 9, 0);
    queue_request(ActAlloc, 0, 0, 0);
    queue_request(ActAlloc, 0, 3, 0);
    queue_request(ActAdd, 768, 8, 1);
    queue_request(ActFree, 512, 0, 0);
    for (int i = 0; i < NumRandom; i++) queue_random_item();
    total_items = pending_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
